// File: rtl/lkt_pkg.sv
// Shared constants, types and state codes for the LRU key tracker.
package lkt_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int KEY_BITS    = 64;
    localparam int CAP_W       = 6;
    localparam int FILL_W      = 6;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int EFF_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(20);

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [CNT_W-1:0]    t_cnt;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    // Control broadcast from the sequencer to every cell of the stack.
    typedef struct packed {
        logic cmp;
        logic upd;
        logic hit;
        logic evict;
        t_cnt limit;
        t_cnt last;
        t_cnt count;
    } t_cell_ctl;

endpackage

// File: rtl/lru_key_tracker_unit.sv
// Top level of the LRU key tracker: sequencer, capacity register and cell stack.
//
// Channel | Direction | Handshake          | Word
// touch   | in        | start / busy       | i_key
// result  | out       | o_valid (strobe)   | o_hit, o_evicted, o_evicted_key, o_fill
// config  | in        | i_cfg_we           | i_cfg_wdata (capacity)
//
// Each key goes through a compare state, which matches it against every
// held place, and an update state, which ripples the shift boundary down
// the cell stack and moves the keys. The result strobes for one cycle
// after the update state; busy is already low then, so the next key can
// be accepted while the result is shown. Reset empties the tracker and
// sets capacity to 20. Results are never held off by the receiver.
module lru_key_tracker_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [63:0]                i_key,
    input  logic                       i_cfg_we,
    input  logic [lkt_pkg::CAP_W-1:0]  i_cfg_wdata,
    output logic                       o_valid,
    output logic                       o_hit,
    output logic                       o_evicted,
    output logic [63:0]                o_evicted_key,
    output logic [lkt_pkg::FILL_W-1:0] o_fill
);

    localparam int N = lkt_pkg::MAX_ENTRIES;

    lkt_pkg::t_state             r_state, n_state;
    logic [lkt_pkg::CAP_W-1:0]   r_cap;
    lkt_pkg::t_cnt               r_count, n_count;
    lkt_pkg::t_key               r_key;
    logic                        r_valid, n_valid;
    logic                        r_hit, r_evict;
    lkt_pkg::t_key               r_ev_key;

    lkt_pkg::t_cell_ctl          w_ctl;
    logic [lkt_pkg::EFF_W-1:0]   w_eff_cap;
    logic                        w_hit;
    logic                        w_evict;
    lkt_pkg::t_key               w_tail;
    logic                        w_accept;

    logic          go   [N+1];
    lkt_pkg::t_key keys [N];
    lkt_pkg::t_key tails[N];
    logic          hits [N];

    assign w_accept = start && !busy;
    assign busy     = (r_state != lkt_pkg::ST_IDLE);

    // zero capacity acts as one, anything above the stack depth saturates
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = lkt_pkg::EFF_W'(1);
        end else if (lkt_pkg::EFF_W'(r_cap) > lkt_pkg::EFF_W'(N)) begin
            w_eff_cap = lkt_pkg::EFF_W'(N);
        end else begin
            w_eff_cap = lkt_pkg::EFF_W'(r_cap);
        end
    end

    always_comb begin
        w_hit  = 1'b0;
        w_tail = '0;
        for (int i = 0; i < N; i++) begin
            w_hit  = w_hit | hits[i];
            w_tail = w_tail | tails[i];
        end
    end

    assign w_evict = !w_hit && (lkt_pkg::EFF_W'(r_count) >= w_eff_cap);

    always_comb begin
        w_ctl.cmp   = (r_state == lkt_pkg::ST_CMP);
        w_ctl.upd   = (r_state == lkt_pkg::ST_UPD);
        w_ctl.hit   = w_hit;
        w_ctl.evict = w_evict;
        w_ctl.last  = r_count - lkt_pkg::CNT_W'(1);
        w_ctl.limit = w_evict ? (r_count - lkt_pkg::CNT_W'(1)) : r_count;
        w_ctl.count = r_count;
    end

    assign go[0] = 1'b1;

    for (genvar g = 0; g < N; g++) begin : g_cell
        lkt_pkg::t_key w_prev;
        if (g == 0) begin : g_head
            assign w_prev = r_key;
        end else begin : g_body
            assign w_prev = keys[g-1];
        end
        lkt_cell u_cell (
            .i_clk      (i_clk),
            .i_idx      (lkt_pkg::CNT_W'(g)),
            .i_ctl      (w_ctl),
            .i_key      (r_key),
            .i_prev_key (w_prev),
            .i_go       (go[g]),
            .o_go       (go[g+1]),
            .o_key      (keys[g]),
            .o_hit      (hits[g]),
            .o_tail_key (tails[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_valid = 1'b0;
        unique case (r_state)
            lkt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = lkt_pkg::ST_CMP;
                end
            end
            lkt_pkg::ST_CMP: begin
                n_state = lkt_pkg::ST_UPD;
            end
            lkt_pkg::ST_UPD: begin
                n_state = lkt_pkg::ST_IDLE;
                n_valid = 1'b1;
                if (!w_hit && !w_evict) begin
                    n_count = r_count + lkt_pkg::CNT_W'(1);
                end
            end
            default: begin
                n_state = lkt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkt_pkg::ST_IDLE;
            r_count <= '0;
            r_cap   <= lkt_pkg::CAP_RESET;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // payload: hold the key for the whole item, capture the result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_key[lkt_pkg::KEY_BITS-1:0];
        end
        if (r_state == lkt_pkg::ST_UPD) begin
            r_hit    <= w_hit;
            r_evict  <= w_evict;
            r_ev_key <= w_tail;
        end
    end

    assign o_valid       = r_valid;
    assign o_hit         = r_hit;
    assign o_evicted     = r_evict;
    assign o_evicted_key = 64'(r_ev_key);
    assign o_fill        = lkt_pkg::FILL_W'(r_count);

endmodule

// File: rtl/lkt_cell.sv
// One place of the recency stack: key storage, compare and shift.
module lkt_cell (
    input  logic               i_clk,
    input  lkt_pkg::t_cnt      i_idx,
    input  lkt_pkg::t_cell_ctl i_ctl,
    input  lkt_pkg::t_key      i_key,
    input  lkt_pkg::t_key      i_prev_key,
    input  logic               i_go,
    output logic               o_go,
    output lkt_pkg::t_key      o_key,
    output logic               o_hit,
    output lkt_pkg::t_key      o_tail_key
);

    lkt_pkg::t_key r_key;
    logic          r_match;
    logic          w_valid;
    logic          w_stop;

    assign w_valid = (i_idx < i_ctl.count);

    // on a hit stop below the matching place, on a miss below the limit
    assign w_stop = i_ctl.hit ? r_match : (i_idx == i_ctl.limit);
    assign o_go   = i_go & ~w_stop;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= w_valid && (r_key == i_key);
        end
        if (i_ctl.upd && i_go) begin
            r_key <= i_prev_key;
        end
    end

    assign o_key      = r_key;
    assign o_hit      = r_match;
    assign o_tail_key = (i_ctl.evict && (i_idx == i_ctl.last)) ? r_key : '0;

endmodule

// File: rtl/lkt_checker.sv
// Port-level checks on the LRU key tracker, bound to the top level.
module lkt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_hit,
    input logic        o_evicted,
    input logic [63:0] o_evicted_key
);

    // an accepted word always yields a result strobe
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##2 o_valid)
        else $error("accepted word produced no result");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted))
        else $error("hit and eviction reported together");

    a_ev_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_evicted) |-> (o_evicted_key == 64'd0))
        else $error("evicted key not zero without eviction");

endmodule

bind lru_key_tracker_unit lkt_checker u_lkt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_hit         (o_hit),
    .o_evicted     (o_evicted),
    .o_evicted_key (o_evicted_key)
);
